// File: hdl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hdl/nrtd_pkg.sv
package nrtd_pkg;
  localparam int unsigned ACC_W = 10;
  localparam int unsigned ANG_W = 15;
  localparam int unsigned SQ_STEPS = 19;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned RAD_W = 38;
  localparam int unsigned REM_W = 40;
  localparam int unsigned CV_W = 24;
  localparam int unsigned Z_W = 19;
  localparam logic [ACC_W-1:0] ZERO_RESET = 10'd512;
  localparam logic [ANG_W-1:0] HALF_PI_Q13 = 15'd12868;
  localparam logic [7:0] MASK_X = 8'h0C;
  localparam logic [7:0] MASK_Y = 8'h30;
  localparam logic [7:0] MASK_Z = 8'hC0;
  localparam logic [7:0] MASK_BTN = 8'h03;

  typedef struct packed {
    logic [7:0] joy_x;
    logic [7:0] joy_y;
    logic [ACC_W-1:0] accel_x;
    logic [ACC_W-1:0] accel_y;
    logic [ACC_W-1:0] accel_z;
    logic z_pressed;
    logic c_pressed;
  } side_t;

  typedef struct packed {
    logic vld;
    side_t side;
    logic zero_den;
    logic signed [ACC_W+1:0] num;
    logic [RAD_W-1:0] rad;
    logic [REM_W-1:0] rem;
    logic [20:0] root;
  } sq_t;

  typedef struct packed {
    logic vld;
    side_t side;
    logic zero_den;
    logic signed [ACC_W+1:0] num;
    logic signed [CV_W-1:0] x;
    logic signed [CV_W-1:0] y;
    logic signed [Z_W-1:0] z;
  } cv_t;

  function automatic logic signed [Z_W-1:0] atan_q16(input logic [3:0] i);
    logic signed [Z_W-1:0] t;
    case (i)
      4'd0: t = 19'sd51472;
      4'd1: t = 19'sd30386;
      4'd2: t = 19'sd16055;
      4'd3: t = 19'sd8150;
      4'd4: t = 19'sd4091;
      4'd5: t = 19'sd2047;
      4'd6: t = 19'sd1024;
      4'd7: t = 19'sd512;
      4'd8: t = 19'sd256;
      4'd9: t = 19'sd128;
      4'd10: t = 19'sd64;
      4'd11: t = 19'sd32;
      4'd12: t = 19'sd16;
      4'd13: t = 19'sd8;
      4'd14: t = 19'sd4;
      default: t = 19'sd2;
    endcase
    return t;
  endfunction
endpackage

// File: hdl/nunchuk_report_tilt_decoder.sv
// Nunchuk report decoder with tilt angle.
// The input channel carries one six-byte report and a pitch/roll select per
// word; the output channel returns one decoded word per input word, in order.
// Both channels use valid/stall: a word moves on a clock edge with valid high
// and stall low.
// The pipeline is a register that unpacks and squares, nineteen cells of the
// integer square root, sixteen CORDIC cells and an output register. Throughput
// is one word per cycle while the receiver does not stall, as every cell hands
// its word to the next cell, so the pipeline holds up to 37 words in flight.
// When the receiver stalls while a result is held, the whole chain freezes and
// in_stall is raised, so nothing is lost or duplicated. Synchronous active-low
// reset clears all valid flags and sets the zero offset to 512. The user must
// write the offset via cfg_we/cfg_wdata only while idle; it is not enforced.
module nunchuk_report_tilt_decoder (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [nrtd_pkg::ACC_W-1:0] cfg_wdata,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] in_report_byte0,
  input  logic [7:0] in_report_byte1,
  input  logic [7:0] in_report_byte2,
  input  logic [7:0] in_report_byte3,
  input  logic [7:0] in_report_byte4,
  input  logic [7:0] in_report_byte5,
  input  logic in_want_roll,
  output logic out_valid,
  input  logic out_stall,
  output logic [7:0] out_joy_x,
  output logic [7:0] out_joy_y,
  output logic [nrtd_pkg::ACC_W-1:0] out_accel_x,
  output logic [nrtd_pkg::ACC_W-1:0] out_accel_y,
  output logic [nrtd_pkg::ACC_W-1:0] out_accel_z,
  output logic out_z_pressed,
  output logic out_c_pressed,
  output logic signed [nrtd_pkg::ANG_W-1:0] out_tilt_angle
);
  import nrtd_pkg::*;
  `include "assert_macros.svh"

  logic en;
  logic [ACC_W-1:0] zero_r;
  sq_t sq [SQ_STEPS+1];
  cv_t cv [CORDIC_STEPS+1];
  logic out_valid_r;
  side_t side_r;
  logic signed [ANG_W-1:0] ang_r, ang_nxt;
  logic signed [Z_W-1:0] zf;
  logic [Z_W-1:0] mag;
  logic [Z_W-1:0] magr;

  assign en = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) zero_r <= ZERO_RESET;
    else if (cfg_we) zero_r <= cfg_wdata;
  end

  nrtd_front u_front (
    .clk(clk), .en(en), .in_vld(in_valid && rst_n),
    .b0(in_report_byte0), .b1(in_report_byte1), .b2(in_report_byte2),
    .b3(in_report_byte3), .b4(in_report_byte4), .b5(in_report_byte5),
    .want_roll(in_want_roll), .zero_ofs(zero_r), .q(sq[0])
  );

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
    nrtd_sqrt_cell u_cell (.clk(clk), .rst_n(rst_n), .en(en), .d(sq[g]), .q(sq[g+1]));
  end

  always_comb begin
    cv[0].vld = sq[SQ_STEPS].vld;
    cv[0].side = sq[SQ_STEPS].side;
    cv[0].zero_den = sq[SQ_STEPS].zero_den;
    cv[0].num = sq[SQ_STEPS].num;
    cv[0].x = CV_W'(sq[SQ_STEPS].root);
    cv[0].y = CV_W'(sq[SQ_STEPS].num) <<< 8;
    cv[0].z = '0;
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cv
    nrtd_cordic_cell #(.STEP(4'(g))) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .d(cv[g]), .q(cv[g+1])
    );
  end

  always_comb begin
    zf = cv[CORDIC_STEPS].z;
    mag = zf[Z_W-1] ? Z_W'(-zf) : Z_W'(zf);
    magr = (mag + Z_W'(4)) >> 3;
    if (magr > Z_W'(HALF_PI_Q13)) magr = Z_W'(HALF_PI_Q13);
    if (cv[CORDIC_STEPS].zero_den) begin
      if (cv[CORDIC_STEPS].num > 0) ang_nxt = $signed(HALF_PI_Q13);
      else if (cv[CORDIC_STEPS].num < 0) ang_nxt = -$signed(HALF_PI_Q13);
      else ang_nxt = '0;
    end else begin
      ang_nxt = zf[Z_W-1] ? -$signed(ANG_W'(magr)) : $signed(ANG_W'(magr));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= cv[CORDIC_STEPS].vld;
    if (en) begin
      side_r <= cv[CORDIC_STEPS].side;
      ang_r <= ang_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_joy_x = side_r.joy_x;
  assign out_joy_y = side_r.joy_y;
  assign out_accel_x = side_r.accel_x;
  assign out_accel_y = side_r.accel_y;
  assign out_accel_z = side_r.accel_z;
  assign out_z_pressed = side_r.z_pressed;
  assign out_c_pressed = side_r.c_pressed;
  assign out_tilt_angle = ang_r;

  `ASSERT_CLK(a_stall_only_held, clk, rst_n, !in_stall || out_valid, "stall without result")
  `ASSERT_NEXT(a_hold_valid, clk, rst_n, out_valid && out_stall, out_valid, "result dropped")
  `ASSERT_NEXT(a_hold_angle, clk, rst_n, out_valid && out_stall, $stable(out_tilt_angle), "angle moved")
  `ASSERT_CLK(a_angle_range, clk, rst_n,
    !out_valid || (out_tilt_angle <= 15'sd12868 && out_tilt_angle >= -15'sd12868), "angle range")
endmodule

// File: hdl/nrtd_front.sv
module nrtd_front (
  input  logic clk,
  input  logic en,
  input  logic in_vld,
  input  logic [7:0] b0, b1, b2, b3, b4, b5,
  input  logic want_roll,
  input  logic [nrtd_pkg::ACC_W-1:0] zero_ofs,
  output nrtd_pkg::sq_t q
);
  import nrtd_pkg::*;
  logic [ACC_W-1:0] ax, ay, az;
  logic signed [ACC_W+1:0] cx, cy, cz, na, nb, nc;
  logic [20:0] s;
  sq_t d, q_r;

  always_comb begin
    ax = {b2, 2'((b5 & MASK_X) >> 2)};
    ay = {b3, 2'((b5 & MASK_Y) >> 4)};
    az = {b4, 2'((b5 & MASK_Z) >> 6)};
    cx = $signed({2'b00, ax}) - $signed({2'b00, zero_ofs});
    cy = $signed({2'b00, ay}) - $signed({2'b00, zero_ofs});
    cz = $signed({2'b00, az}) - $signed({2'b00, zero_ofs});
    na = want_roll ? cy : cx;
    nb = want_roll ? cx : cy;
    nc = cz;
    s = 21'(nb * nb) + 21'(nc * nc);
    d.vld = in_vld;
    d.side.joy_x = b0;
    d.side.joy_y = b1;
    d.side.accel_x = ax;
    d.side.accel_y = ay;
    d.side.accel_z = az;
    d.side.z_pressed = ~(|(b5 & MASK_BTN & 8'h01));
    d.side.c_pressed = ~(|(b5 & MASK_BTN & 8'h02));
    d.zero_den = (s == 21'd0);
    d.num = na;
    d.rad = {1'b0, s, 16'd0};
    d.rem = '0;
    d.root = '0;
  end

  always_ff @(posedge clk) begin
    if (en) q_r <= d;
  end
  assign q = q_r;
endmodule

// File: hdl/nrtd_sqrt_cell.sv
module nrtd_sqrt_cell (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  nrtd_pkg::sq_t d,
  output nrtd_pkg::sq_t q
);
  import nrtd_pkg::*;
  sq_t q_r, q_nxt;
  logic [REM_W-1:0] rm, tr;

  always_comb begin
    q_nxt = d;
    rm = {d.rem[REM_W-3:0], d.rad[RAD_W-1:RAD_W-2]};
    tr = {17'd0, d.root, 2'b01};
    q_nxt.rad = {d.rad[RAD_W-3:0], 2'b00};
    if (rm >= tr) begin
      q_nxt.rem = rm - tr;
      q_nxt.root = {d.root[19:0], 1'b1};
    end else begin
      q_nxt.rem = rm;
      q_nxt.root = {d.root[19:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) q_r.vld <= 1'b0;
    else if (en) q_r.vld <= q_nxt.vld;
    if (en) begin
      q_r.side <= q_nxt.side;
      q_r.zero_den <= q_nxt.zero_den;
      q_r.num <= q_nxt.num;
      q_r.rad <= q_nxt.rad;
      q_r.rem <= q_nxt.rem;
      q_r.root <= q_nxt.root;
    end
  end
  assign q = q_r;
endmodule

// File: hdl/nrtd_cordic_cell.sv
module nrtd_cordic_cell #(
  parameter logic [3:0] STEP = 4'd0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  nrtd_pkg::cv_t d,
  output nrtd_pkg::cv_t q
);
  import nrtd_pkg::*;
  cv_t q_r, q_nxt;
  logic signed [CV_W-1:0] xs, ys;

  always_comb begin
    q_nxt = d;
    xs = d.x >>> STEP;
    ys = d.y >>> STEP;
    if (!d.y[CV_W-1]) begin
      q_nxt.x = d.x + ys;
      q_nxt.y = d.y - xs;
      q_nxt.z = d.z + atan_q16(STEP);
    end else begin
      q_nxt.x = d.x - ys;
      q_nxt.y = d.y + xs;
      q_nxt.z = d.z - atan_q16(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) q_r.vld <= 1'b0;
    else if (en) q_r.vld <= q_nxt.vld;
    if (en) begin
      q_r.side <= q_nxt.side;
      q_r.zero_den <= q_nxt.zero_den;
      q_r.num <= q_nxt.num;
      q_r.x <= q_nxt.x;
      q_r.y <= q_nxt.y;
      q_r.z <= q_nxt.z;
    end
  end
  assign q = q_r;
endmodule

// File: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nrtd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned N_RANDOM = 1500;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] b5;
    logic roll;
  } report_t;

  typedef struct packed {
    logic [7:0] joy_x;
    logic [7:0] joy_y;
    logic [ACC_W-1:0] accel_x;
    logic [ACC_W-1:0] accel_y;
    logic [ACC_W-1:0] accel_z;
    logic z_pressed;
    logic c_pressed;
    logic signed [ANG_W-1:0] tilt;
  } decoded_t;

  typedef struct {
    report_t rpt;
    logic has_tilt;
    logic signed [ANG_W-1:0] tilt;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ACC_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  report_t in_rpt = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_joy_x, out_joy_y;
  logic [ACC_W-1:0] out_accel_x, out_accel_y, out_accel_z;
  logic out_z_pressed, out_c_pressed;
  logic signed [ANG_W-1:0] out_tilt_angle;

  logic [ACC_W-1:0] zero_offset;
  decoded_t pending_decodes[$];
  int errors = 0;
  int checked = 0;
  int sent = 0;
  int idle_cycles = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  logic timed_out = 1'b0;

  always #4 clk = ~clk;

  nunchuk_report_tilt_decoder dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_report_byte0(in_rpt.b0), .in_report_byte1(in_rpt.b1),
    .in_report_byte2(in_rpt.b2), .in_report_byte3(in_rpt.b3),
    .in_report_byte4(in_rpt.b4), .in_report_byte5(in_rpt.b5),
    .in_want_roll(in_rpt.roll),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_joy_x(out_joy_x), .out_joy_y(out_joy_y),
    .out_accel_x(out_accel_x), .out_accel_y(out_accel_y),
    .out_accel_z(out_accel_z), .out_z_pressed(out_z_pressed),
    .out_c_pressed(out_c_pressed), .out_tilt_angle(out_tilt_angle)
  );

  function automatic longint floor_shift(longint v, int k);
    if (v >= 0) return v >>> k;
    return -((-(v + 1)) >>> k) - 1;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint root = 0;
    longint bitv = 64'sd1 << 60;
    while (bitv > n) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - root - bitv;
        root = (root >>> 1) + bitv;
      end else begin
        root = root >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return root;
  endfunction

  function automatic logic signed [ANG_W-1:0] tilt_angle(int a, int b, int c);
    longint atan_q16[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2};
    longint s, x, y, z, xs, ys, mag;
    s = longint'(b) * b + longint'(c) * c;
    if (s == 0) return (a > 0) ? 15'sd12868 : (a < 0) ? -15'sd12868 : 15'sd0;
    x = int_sqrt(s << 16);
    y = longint'(a) * 256;
    z = 0;
    for (int i = 0; i < 16; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_q16[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_q16[i];
      end
    end
    mag = ((z < 0 ? -z : z) + 4) >>> 3;
    if (mag > 12868) mag = 12868;
    return (z < 0) ? ANG_W'(-mag) : ANG_W'(mag);
  endfunction

  function automatic decoded_t decode_report(report_t r);
    decoded_t d;
    int cx, cy, cz;
    d.joy_x = r.b0;
    d.joy_y = r.b1;
    d.accel_x = {r.b2, r.b5[3:2]};
    d.accel_y = {r.b3, r.b5[5:4]};
    d.accel_z = {r.b4, r.b5[7:6]};
    d.z_pressed = ~r.b5[0];
    d.c_pressed = ~r.b5[1];
    cx = int'(d.accel_x) - int'(zero_offset);
    cy = int'(d.accel_y) - int'(zero_offset);
    cz = int'(d.accel_z) - int'(zero_offset);
    d.tilt = r.roll ? tilt_angle(cy, cx, cz) : tilt_angle(cx, cy, cz);
    return d;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch on word %0d: %s got %0d expected %0d", checked, what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (pending_decodes.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          decoded_t e;
          e = pending_decodes.pop_front();
          if (out_joy_x !== e.joy_x) report_mismatch("joy_x", out_joy_x, e.joy_x);
          if (out_joy_y !== e.joy_y) report_mismatch("joy_y", out_joy_y, e.joy_y);
          if (out_accel_x !== e.accel_x) report_mismatch("accel_x", out_accel_x, e.accel_x);
          if (out_accel_y !== e.accel_y) report_mismatch("accel_y", out_accel_y, e.accel_y);
          if (out_accel_z !== e.accel_z) report_mismatch("accel_z", out_accel_z, e.accel_z);
          if (out_z_pressed !== e.z_pressed)
            report_mismatch("z_pressed", out_z_pressed, e.z_pressed);
          if (out_c_pressed !== e.c_pressed)
            report_mismatch("c_pressed", out_c_pressed, e.c_pressed);
          if (out_tilt_angle !== e.tilt) report_mismatch("tilt_angle", out_tilt_angle, e.tilt);
        end
        checked <= checked + 1;
      end
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d words outstanding", pending_decodes.size());
      $display("** nunchuk_report_tilt_decoder: FAILED **");
      $finish;
    end
  end

  task automatic send_report(report_t r, logic has_tilt, logic signed [ANG_W-1:0] tilt);
    decoded_t d;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    d = decode_report(r);
    if (has_tilt && d.tilt !== tilt) report_mismatch("predicted tilt", d.tilt, tilt);
    if (has_tilt) d.tilt = tilt;
    pending_decodes.push_back(d);
    in_rpt <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_offset(logic [ACC_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    zero_offset = v;
  endtask

  function automatic report_t random_report();
    report_t r;
    r = $bits(report_t)'({$urandom, $urandom});
    if ($urandom_range(9) == 0) begin
      r.b2 = 8'(zero_offset >> 2);
      r.b5[3:2] = zero_offset[1:0];
      r.b3 = 8'(zero_offset >> 2);
      r.b5[5:4] = zero_offset[1:0];
      r.b4 = 8'(zero_offset >> 2);
      r.b5[7:6] = zero_offset[1:0];
      if ($urandom_range(1)) r.b2 = 8'($urandom);
      else r.b3 = 8'($urandom);
    end
    return r;
  endfunction

  initial begin
    stim_row_t rows[$];
    logic [ACC_W-1:0] offsets[6] = '{10'd0, 10'd1023, 10'd512, 10'd300, 10'd777, 10'd512};
    rows.push_back('{report_t'{8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h00, 1'b0}, 1'b1, 15'sd0});
    rows.push_back('{report_t'{8'hff, 8'hff, 8'hff, 8'h80, 8'h80, 8'h0f, 1'b0}, 1'b1, 15'sd12868});
    rows.push_back('{report_t'{8'h12, 8'h34, 8'h00, 8'h80, 8'h80, 8'h03, 1'b0}, 1'b1, -15'sd12868});
    rows.push_back('{report_t'{8'h55, 8'haa, 8'h80, 8'hff, 8'h80, 8'h32, 1'b1}, 1'b1, 15'sd12868});
    rows.push_back('{report_t'{8'haa, 8'h55, 8'h80, 8'h00, 8'h80, 8'h01, 1'b1}, 1'b1, -15'sd12868});
    rows.push_back('{report_t'{8'h01, 8'h02, 8'h80, 8'h80, 8'h80, 8'h02, 1'b1}, 1'b1, 15'sd0});
    rows.push_back('{report_t'{8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0}, 1'b0, 15'sd0});
    rows.push_back('{report_t'{8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b0, 15'sd0});
    rows.push_back('{report_t'{8'h80, 8'h80, 8'hff, 8'hff, 8'h00, 8'h3c, 1'b0}, 1'b0, 15'sd0});
    rows.push_back('{report_t'{8'h7f, 8'h7f, 8'h00, 8'hff, 8'hff, 8'hc0, 1'b1}, 1'b0, 15'sd0});
    rows.push_back('{report_t'{8'h3c, 8'hc3, 8'h90, 8'h40, 8'hc0, 8'h5a, 1'b0}, 1'b0, 15'sd0});
    rows.push_back('{report_t'{8'hc3, 8'h3c, 8'h40, 8'h90, 8'hc0, 8'ha5, 1'b1}, 1'b0, 15'sd0});

    zero_offset = ZERO_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) send_report(rows[i].rpt, rows[i].has_tilt, rows[i].tilt);
    drain_pipeline();

    for (int phase = 0; phase < 6; phase++) begin
      write_offset(offsets[phase]);
      in_idle_pct = (phase % 3 == 0) ? 9 : (phase % 3 == 1) ? 78 : 0;
      out_idle_pct = (phase % 3 == 0) ? 78 : (phase % 3 == 1) ? 9 : 0;
      for (int n = 0; n < N_RANDOM / 6; n++) begin
        send_report(random_report(), 1'b0, 15'sd0);
        if (n == 40) begin
          in_valid <= 1'b0;
          while (pending_decodes.size() != 0) @(posedge clk);
        end
      end
      foreach (rows[i]) if (!rows[i].has_tilt) send_report(rows[i].rpt, 1'b0, 15'sd0);
      drain_pipeline();
    end

    $display("Sent %0d reports over six zero-offset settings (0, 1023, 512 and others),",
             sent);
    $display("with idle and stall mixes on both sides; %0d decoded words checked.", checked);
    if (errors == 0 && pending_decodes.size() == 0) begin
      $display("** nunchuk_report_tilt_decoder: PASSED **");
    end else begin
      $display("** nunchuk_report_tilt_decoder: FAILED **");
    end
    $finish;
  end
endmodule

// File: nunchuk_report_tilt_decoder.f
+incdir+hdl
hdl/nrtd_pkg.sv
hdl/nrtd_front.sv
hdl/nrtd_sqrt_cell.sv
hdl/nrtd_cordic_cell.sv
hdl/nunchuk_report_tilt_decoder.sv
dv/tb.sv
